>>> sv/rrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the reply reorder buffer.
package rrb_pkg;

    localparam int ID_W     = 64;
    localparam int HANDLE_W = 32;

    typedef enum logic [1:0] {
        ST_REPLY  = 2'd0,
        ST_STALE  = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_HOLD
    } state_t;

    // Controls broadcast to every cell of the slot chain
    typedef struct packed {
        logic clear;
        logic shift;
    } chain_ctrl_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
        logic                last;
    } rsp_t;

endpackage

>>> sv/rrb_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the reply reorder buffer.
interface rrb_req_if
    import rrb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     request_id;
    logic [HANDLE_W-1:0] reply_handle;

    modport source (output valid, output request_id, output reply_handle, input ready);
    modport sink   (input valid, input request_id, input reply_handle, output ready);
endinterface

interface rrb_rsp_if
    import rrb_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     out_id;
    logic [HANDLE_W-1:0] out_handle;
    status_t             status;
    logic                last;

    modport source (output valid, output out_id, output out_handle, output status,
                    output last, input ready);
    modport sink   (input valid, input out_id, input out_handle, input status,
                    input last, output ready);
endinterface

>>> sv/reply_reorder_buffer_unit.sv
`timescale 1ns / 1ps
// Top level of the reply reorder buffer.
//
// Replies come in on the req channel (request_id, reply_handle) in any order
// and leave on the rsp channel in request-id order, both valid/ready.
// A reply inside the window [expected id, expected id + WINDOW) is written
// into its cell of the slot chain in the cycle it is accepted. When it fills
// the expected id, the chain drains one reply per cycle while the output
// register can take it: the head cell is sent, every cell takes its
// neighbour's slot and the expected id advances; last marks the end of the
// run. No request is taken while it drains. A gap-leaving insert, or a drop
// with the output free, keeps the block idle. A stale or beyond-window id
// gives one status result with handle zero; if the output register is still
// full it waits in a hold register and further requests wait with it. The
// rsp side is one output register: while it stalls, the drain and any drop
// hold their place. Reset clears all valid bits and sets the expected id to
// zero; a write of cfg_wdata reloads the expected id and clears the chain.
// The user must make it only while the block is idle; it is not enforced.
module reply_reorder_buffer_unit
    import rrb_pkg::*;
#(
    parameter int WINDOW      = 32,
    parameter int HANDLE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    rrb_req_if.sink          req,
    rrb_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [ID_W-1:0]  cfg_wdata
);

    localparam int HW   = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int OFFW = $clog2(WINDOW);

    state_t          state_reg;
    state_t          state_next;
    logic [ID_W-1:0] expected_reg;
    logic [ID_W-1:0] expected_next;
    logic [ID_W-1:0] hold_id_reg;
    logic [ID_W-1:0] hold_id_next;
    status_t         hold_status_reg;
    status_t         hold_status_next;
    logic            ov_reg;
    logic            ov_next;
    rsp_t            out_reg;
    rsp_t            out_next;

    logic            accept;
    logic            out_free;
    logic [ID_W-1:0] diff;
    logic            stale;
    logic            beyond;
    logic            in_win;
    status_t         drop_status;
    logic            load;
    rsp_t            load_val;
    chain_ctrl_t     ctrl;
    logic            head_valid;
    logic [HW-1:0]   head_handle;
    logic            second_valid;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !ov_reg || rsp.ready;

    assign diff        = req.request_id - expected_reg;
    assign stale       = req.request_id < expected_reg;
    assign beyond      = !stale && (diff >= ID_W'(WINDOW));
    assign in_win      = accept && !stale && !beyond;
    assign drop_status = stale ? ST_STALE : ST_BEYOND;

    rrb_chain #(
        .WINDOW (WINDOW),
        .HW     (HW),
        .OFFW   (OFFW)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .wr_en        (in_win),
        .wr_offset    (diff[OFFW-1:0]),
        .wr_handle    (req.reply_handle[HW-1:0]),
        .head_valid   (head_valid),
        .head_handle  (head_handle),
        .second_valid (second_valid)
    );

    always_comb
    begin
        state_next       = state_reg;
        expected_next    = expected_reg;
        hold_id_next     = hold_id_reg;
        hold_status_next = hold_status_reg;
        ctrl.clear       = cfg_we;
        ctrl.shift       = 1'b0;
        load             = 1'b0;
        load_val         = '{id: req.request_id, handle: '0, status: drop_status, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stale || beyond)
                    begin
                        if (out_free)
                        begin
                            load = 1'b1;
                        end
                        else
                        begin
                            hold_id_next     = req.request_id;
                            hold_status_next = drop_status;
                            state_next       = S_HOLD;
                        end
                    end
                    else if (diff[OFFW-1:0] == '0)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_HOLD:
            begin
                load_val = '{id: hold_id_reg, handle: '0, status: hold_status_reg,
                             last: 1'b1};
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                load_val = '{id: expected_reg, handle: HANDLE_W'(head_handle),
                             status: ST_REPLY, last: !second_valid};
                if (!head_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    load          = 1'b1;
                    ctrl.shift    = 1'b1;
                    expected_next = expected_reg + ID_W'(1);
                    if (!second_valid)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            expected_next = cfg_wdata;
        end

        ov_next  = ov_reg;
        out_next = out_reg;
        if (load)
        begin
            ov_next  = 1'b1;
            out_next = load_val;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            expected_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_id_reg     <= hold_id_next;
        hold_status_reg <= hold_status_next;
        out_reg         <= out_next;
    end

    assign rsp.valid      = ov_reg;
    assign rsp.out_id     = out_reg.id;
    assign rsp.out_handle = out_reg.handle;
    assign rsp.status     = out_reg.status;
    assign rsp.last       = out_reg.last;

endmodule

>>> sv/rrb_cell.sv
`timescale 1ns / 1ps
// One slot of the reorder chain: a valid bit and a stored handle.
module rrb_cell
    import rrb_pkg::*;
#(
    parameter int HW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  chain_ctrl_t   ctrl,
    input  logic          wr_en,
    input  logic [HW-1:0] wr_handle,
    input  logic          nb_valid,
    input  logic [HW-1:0] nb_handle,
    output logic          valid,
    output logic [HW-1:0] handle
);

    logic          valid_reg;
    logic          valid_next;
    logic [HW-1:0] handle_reg;
    logic [HW-1:0] handle_next;

    always_comb
    begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            // take the neighbour's slot, one id further on
            valid_next  = nb_valid;
            handle_next = nb_handle;
        end
        else if (wr_en)
        begin
            valid_next  = 1'b1;
            handle_next = wr_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
    end

    assign valid  = valid_reg;
    assign handle = handle_reg;

endmodule

>>> sv/rrb_chain.sv
`timescale 1ns / 1ps
// Row of slot cells; cell k holds the reply for expected id plus k.
module rrb_chain
    import rrb_pkg::*;
#(
    parameter int WINDOW = 32,
    parameter int HW     = 32,
    parameter int OFFW   = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  chain_ctrl_t     ctrl,
    input  logic            wr_en,
    input  logic [OFFW-1:0] wr_offset,
    input  logic [HW-1:0]   wr_handle,
    output logic            head_valid,
    output logic [HW-1:0]   head_handle,
    output logic            second_valid
);

    logic          valid_w  [WINDOW+1];
    logic [HW-1:0] handle_w [WINDOW+1];

    // past the far end of the window nothing is stored
    assign valid_w[WINDOW]  = 1'b0;
    assign handle_w[WINDOW] = '0;

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        logic sel;

        assign sel = wr_en && (wr_offset == OFFW'(k));

        rrb_cell #(
            .HW (HW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_en     (sel),
            .wr_handle (wr_handle),
            .nb_valid  (valid_w[k+1]),
            .nb_handle (handle_w[k+1]),
            .valid     (valid_w[k]),
            .handle    (handle_w[k])
        );
    end

    assign head_valid   = valid_w[0];
    assign head_handle  = handle_w[0];
    assign second_valid = valid_w[1];

endmodule

>>> sv/rrb_check.sv
`timescale 1ns / 1ps
// Port-level checks of the reply reorder buffer and their bind.
module rrb_check
    import rrb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [ID_W-1:0]     rsp_id,
    input logic [HANDLE_W-1:0] rsp_handle,
    input logic [1:0]          rsp_status,
    input logic                rsp_last
);

    // hold a stalled response unchanged
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id) && $stable(rsp_handle)
            && $stable(rsp_status) && $stable(rsp_last))
        else $error("stalled response changed");

    // a drop is a single result with no handle
    a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_REPLY) |-> rsp_last && (rsp_handle == '0))
        else $error("drop result malformed");

    // no request is taken while a release run still has replies to come
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_REPLY) && !rsp_last
            |-> !(req_valid && req_ready))
        else $error("request accepted during a release run");

endmodule

bind reply_reorder_buffer_unit rrb_check u_rrb_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_id     (rsp.out_id),
    .rsp_handle (rsp.out_handle),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last)
);
